// ===== src/smag_pkg.sv =====
// Shared widths, control type and constants for the Smagorinsky viscosity pipeline.
// No dependencies.
package smag_pkg;

    localparam int WordW    = 32;
    localparam int StrainW  = 66;
    localparam int RootW    = 33;
    localparam int VolSqW   = 64;
    localparam int LenW     = 22;
    localparam int SqrtSteps = RootW;
    localparam int CbrtSteps = LenW;
    localparam int StrainLat = 3;
    localparam int ScaleLat  = 3;
    localparam int LenDelay  = StrainLat + SqrtSteps - 1 - CbrtSteps;
    localparam int CfgIdxW   = 2;

    localparam logic [CfgIdxW-1:0] CfgMolVisc = 2'd0;
    localparam logic [CfgIdxW-1:0] CfgDensity = 2'd1;

    localparam logic [WordW-1:0] DensityReset = 32'h0001_0000;
    localparam logic [WordW-1:0] WordMax      = 32'hFFFF_FFFF;

    typedef struct packed {
        logic en;
        logic vld;
    } smag_ctl_t;

endpackage

// ===== src/smag_strain.sv =====
// Strain magnitude front end: gradient magnitudes, squares, weighted sum; volume squared.
// Depends on smag_pkg.
module smag_strain (
    input  logic                          clk,
    input  logic                          rst_n,
    input  smag_pkg::smag_ctl_t           ctl,
    input  logic [31:0]                   du_dx,
    input  logic [31:0]                   du_dy,
    input  logic [31:0]                   dv_dx,
    input  logic [31:0]                   dv_dy,
    input  logic [31:0]                   cell_volume,
    output logic                          vol_vld,
    output logic [smag_pkg::VolSqW-1:0]   vol_sq,
    output logic                          strain_vld,
    output logic [smag_pkg::StrainW-1:0]  strain
);

    logic        v1_reg, v2_reg, v3_reg;
    logic [31:0] mx_reg, my_reg;
    logic [32:0] ms_reg;
    logic [63:0] vv_reg;
    logic [63:0] sx_reg, sy_reg;
    logic [65:0] ss_reg;
    logic [65:0] sum_reg;

    logic [31:0] mx_next, my_next;
    logic [32:0] shear, ms_next;

    always_comb
    begin
        mx_next = du_dx[31] ? (32'd0 - du_dx) : du_dx;
        my_next = dv_dy[31] ? (32'd0 - dv_dy) : dv_dy;
        shear   = {du_dy[31], du_dy} + {dv_dx[31], dv_dx};
        ms_next = shear[32] ? (33'd0 - shear) : shear;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (ctl.en)
        begin
            v1_reg <= ctl.vld;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            mx_reg  <= mx_next;
            my_reg  <= my_next;
            ms_reg  <= ms_next;
            vv_reg  <= {32'd0, cell_volume} * {32'd0, cell_volume};
            sx_reg  <= {32'd0, mx_reg} * {32'd0, mx_reg};
            sy_reg  <= {32'd0, my_reg} * {32'd0, my_reg};
            ss_reg  <= {33'd0, ms_reg} * {33'd0, ms_reg};
            sum_reg <= {1'b0, sx_reg, 1'b0} + {1'b0, sy_reg, 1'b0} + ss_reg;
        end
    end

    assign vol_vld    = v1_reg;
    assign vol_sq     = vv_reg;
    assign strain_vld = v3_reg;
    assign strain     = sum_reg;

endmodule

// ===== src/smag_isqrt.sv =====
// Pipelined integer square root, one result bit per stage.
// Depends on smag_pkg.
module smag_isqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  smag_pkg::smag_ctl_t           ctl,
    input  logic [smag_pkg::StrainW-1:0]  rad,
    output logic                          root_vld,
    output logic [smag_pkg::RootW-1:0]    root
);

    localparam int N    = smag_pkg::SqrtSteps;
    localparam int RadW = smag_pkg::StrainW;
    localparam int RW   = smag_pkg::RootW;
    localparam int RemW = RW + 4;

    logic            vld_reg  [1:N];
    logic [RadW-1:0] rad_reg  [1:N];
    logic [RemW-1:0] rem_reg  [1:N];
    logic [RW-1:0]   root_reg [1:N];

    genvar k;
    generate
        for (k = 0; k < N; k++)
        begin : g_step
            logic            vin;
            logic [RadW-1:0] rin;
            logic [RemW-1:0] remin, rem_sh, trial;
            logic [RW-1:0]   rootin;
            logic            ge;

            if (k == 0)
            begin : g_first
                assign vin    = ctl.vld;
                assign rin    = rad;
                assign remin  = '0;
                assign rootin = '0;
            end
            else
            begin : g_rest
                assign vin    = vld_reg[k];
                assign rin    = rad_reg[k];
                assign remin  = rem_reg[k];
                assign rootin = root_reg[k];
            end

            always_comb
            begin
                rem_sh = {remin[RemW-3:0], rin[RadW-1 -: 2]};
                trial  = {2'b00, rootin, 2'b01};
                ge     = (rem_sh >= trial);
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[k+1] <= 1'b0;
                end
                else if (ctl.en)
                begin
                    vld_reg[k+1] <= vin;
                end
            end

            always_ff @(posedge clk)
            begin
                if (ctl.en)
                begin
                    rad_reg[k+1]  <= {rin[RadW-3:0], 2'b00};
                    rem_reg[k+1]  <= ge ? (rem_sh - trial) : rem_sh;
                    root_reg[k+1] <= {rootin[RW-2:0], ge};
                end
            end
        end
    endgenerate

    assign root_vld = vld_reg[N];
    assign root     = root_reg[N];

endmodule

// ===== src/smag_icbrt.sv =====
// Pipelined integer cube root of the squared volume, one result bit per stage.
// Depends on smag_pkg.
module smag_icbrt (
    input  logic                         clk,
    input  logic                         rst_n,
    input  smag_pkg::smag_ctl_t          ctl,
    input  logic [smag_pkg::VolSqW-1:0]  rad,
    output logic                         root_vld,
    output logic [smag_pkg::LenW-1:0]    root
);

    localparam int N    = smag_pkg::CbrtSteps;
    localparam int RadW = 3 * N;
    localparam int RW   = smag_pkg::LenW;
    localparam int SqW  = 2 * RW + 2;
    localparam int RemW = 2 * RW + 6;

    logic            vld_reg  [1:N];
    logic [RadW-1:0] rad_reg  [1:N];
    logic [RemW-1:0] rem_reg  [1:N];
    logic [RW-1:0]   root_reg [1:N];
    logic [SqW-1:0]  sq_reg   [1:N];

    genvar k;
    generate
        for (k = 0; k < N; k++)
        begin : g_step
            logic            vin;
            logic [RadW-1:0] rin;
            logic [RemW-1:0] remin, rem_sh, t;
            logic [RW-1:0]   rootin, r2;
            logic [SqW-1:0]  sqin, sq4;
            logic            ge;

            if (k == 0)
            begin : g_first
                assign vin    = ctl.vld;
                assign rin    = {{(RadW - smag_pkg::VolSqW){1'b0}}, rad};
                assign remin  = '0;
                assign rootin = '0;
                assign sqin   = '0;
            end
            else
            begin : g_rest
                assign vin    = vld_reg[k];
                assign rin    = rad_reg[k];
                assign remin  = rem_reg[k];
                assign rootin = root_reg[k];
                assign sqin   = sq_reg[k];
            end

            // (2r+1)^3 - (2r)^3 = 3*(2r)^2 + 3*(2r) + 1
            always_comb
            begin
                r2     = {rootin[RW-2:0], 1'b0};
                sq4    = {sqin[SqW-3:0], 2'b00};
                rem_sh = {remin[RemW-4:0], rin[RadW-1 -: 3]};
                t      = {{(RemW - SqW){1'b0}}, sq4}
                       + {{(RemW - SqW - 1){1'b0}}, sq4, 1'b0}
                       + {{(RemW - RW){1'b0}}, r2}
                       + {{(RemW - RW - 1){1'b0}}, r2, 1'b0}
                       + {{(RemW - 1){1'b0}}, 1'b1};
                ge     = (rem_sh >= t);
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[k+1] <= 1'b0;
                end
                else if (ctl.en)
                begin
                    vld_reg[k+1] <= vin;
                end
            end

            always_ff @(posedge clk)
            begin
                if (ctl.en)
                begin
                    rad_reg[k+1]  <= {rin[RadW-4:0], 3'b000};
                    rem_reg[k+1]  <= ge ? (rem_sh - t) : rem_sh;
                    root_reg[k+1] <= {r2[RW-1:1], ge};
                    sq_reg[k+1]   <= ge ? (sq4 + {{(SqW - RW - 1){1'b0}}, r2, 1'b0}
                                           + {{(SqW - 1){1'b0}}, 1'b1})
                                        : sq4;
                end
            end
        end
    endgenerate

    assign root_vld = vld_reg[N];
    assign root     = root_reg[N];

endmodule

// ===== src/smag_scale.sv =====
// Eddy term rho * L * OP / 2^32, molecular add and saturation; last stage is the output register.
// Depends on smag_pkg.
module smag_scale (
    input  logic                        clk,
    input  logic                        rst_n,
    input  smag_pkg::smag_ctl_t         ctl,
    input  logic [smag_pkg::RootW-1:0]  op,
    input  logic [smag_pkg::LenW-1:0]   len,
    input  logic [31:0]                 density,
    input  logic [31:0]                 mol_visc,
    output logic                        res_vld,
    output logic [31:0]                 visc,
    output logic                        sat
);

    localparam int PW   = 32 + smag_pkg::LenW;
    localparam int HalfW = PW / 2;
    localparam int RW   = smag_pkg::RootW;
    localparam int ProdW = PW + RW;

    logic                v1_reg, v2_reg, v3_reg;
    logic [PW-1:0]       p1_reg;
    logic [RW-1:0]       op1_reg;
    logic [HalfW+RW-1:0] pl_reg;
    logic [PW-HalfW+RW-1:0] ph_reg;
    logic [31:0]         visc_reg;
    logic                sat_reg;

    logic [ProdW-1:0]    prod;
    logic [ProdW-32:0]   total;

    always_comb
    begin
        prod  = {{(ProdW - HalfW - RW){1'b0}}, pl_reg}
              + {ph_reg, {HalfW{1'b0}}};
        total = {1'b0, prod[ProdW-1:32]} + {{(ProdW - 64 + 1){1'b0}}, mol_visc};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (ctl.en)
        begin
            v1_reg <= ctl.vld;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            p1_reg  <= {{smag_pkg::LenW{1'b0}}, density} * {32'd0, len};
            op1_reg <= op;
            pl_reg  <= {{RW{1'b0}}, p1_reg[HalfW-1:0]} * {{HalfW{1'b0}}, op1_reg};
            ph_reg  <= {{RW{1'b0}}, p1_reg[PW-1:HalfW]} * {{(PW-HalfW){1'b0}}, op1_reg};
            if (total[ProdW-32:32] != '0)
            begin
                visc_reg <= smag_pkg::WordMax;
                sat_reg  <= 1'b1;
            end
            else
            begin
                visc_reg <= total[31:0];
                sat_reg  <= 1'b0;
            end
        end
    end

    assign res_vld = v3_reg;
    assign visc    = visc_reg;
    assign sat     = sat_reg;

endmodule

// ===== src/smagorinsky_eddy_viscosity_2d_top.sv =====
// Top level of the 2D Smagorinsky apparent viscosity pipeline.
// Depends on smag_pkg, smag_strain, smag_isqrt, smag_icbrt, smag_scale.
//
// Usage:
//   s_axis carries one point per word: four signed Q16.16 velocity gradients and
//   the unsigned Q8.24 cell volume. m_axis returns one word per point: the
//   apparent viscosity mu + rho * V^(2/3) * sqrt(2ux^2 + 2vy^2 + (uy+vx)^2) in
//   unsigned Q16.16, saturated, with the clip flag on tuser.
//   molecular_viscosity (index 0) and fluid_density (index 1) are written on the
//   cfg port while the pipeline is empty.
// Timing:
//   One word per cycle sustained while the receiver is ready. Each word passes through
//   3 strain stages, 33 square-root stages (one root bit each) and 3 scaling stages.
//   The cube root (22 stages) runs alongside the square root.
// Reset clears all valid bits and sets mu = 0, rho = 1.0. A stalled receiver with a valid
// output word freezes the whole pipeline; s_axis_tready follows, nothing is dropped.
module smagorinsky_eddy_viscosity_2d_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // du_dx[31:0], du_dy[63:32], dv_dx[95:64], dv_dy[127:96], cell_volume[159:128]
    input  logic [159:0]                 s_axis_tdata,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // apparent_viscosity[31:0]
    output logic [31:0]                  m_axis_tdata,
    // saturated[0]
    output logic                         m_axis_tuser,
    input  logic                         cfg_we,
    input  logic [smag_pkg::CfgIdxW-1:0] cfg_index,
    input  logic [31:0]                  cfg_data
);

    localparam int D = smag_pkg::LenDelay;

    logic [31:0] mol_visc_reg, density_reg;
    logic        en;

    smag_pkg::smag_ctl_t in_ctl, vol_ctl, str_ctl, sc_ctl;

    logic                          vol_vld, strain_vld, op_vld, len_vld;
    logic [smag_pkg::VolSqW-1:0]   vol_sq;
    logic [smag_pkg::StrainW-1:0]  strain;
    logic [smag_pkg::RootW-1:0]    op;
    logic [smag_pkg::LenW-1:0]     len;
    logic [smag_pkg::LenW-1:0]     len_reg [1:D];

    assign en            = m_axis_tready || !m_axis_tvalid;
    assign s_axis_tready = en;

    assign in_ctl  = '{en: en, vld: s_axis_tvalid};
    assign vol_ctl = '{en: en, vld: vol_vld};
    assign str_ctl = '{en: en, vld: strain_vld};
    assign sc_ctl  = '{en: en, vld: op_vld};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mol_visc_reg <= '0;
            density_reg  <= smag_pkg::DensityReset;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                smag_pkg::CfgMolVisc: mol_visc_reg <= cfg_data;
                smag_pkg::CfgDensity: density_reg  <= cfg_data;
                default:              ;
            endcase
        end
    end

    smag_strain u_strain (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (in_ctl),
        .du_dx       (s_axis_tdata[31:0]),
        .du_dy       (s_axis_tdata[63:32]),
        .dv_dx       (s_axis_tdata[95:64]),
        .dv_dy       (s_axis_tdata[127:96]),
        .cell_volume (s_axis_tdata[159:128]),
        .vol_vld     (vol_vld),
        .vol_sq      (vol_sq),
        .strain_vld  (strain_vld),
        .strain      (strain)
    );

    smag_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (str_ctl),
        .rad      (strain),
        .root_vld (op_vld),
        .root     (op)
    );

    smag_icbrt u_icbrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (vol_ctl),
        .rad      (vol_sq),
        .root_vld (len_vld),
        .root     (len)
    );

    // align cube root with square root
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            len_reg[1] <= len;
            for (int i = 2; i <= D; i++)
            begin
                len_reg[i] <= len_reg[i-1];
            end
        end
    end

    smag_scale u_scale (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (sc_ctl),
        .op       (op),
        .len      (len_reg[D]),
        .density  (density_reg),
        .mol_visc (mol_visc_reg),
        .res_vld  (m_axis_tvalid),
        .visc     (m_axis_tdata),
        .sat      (m_axis_tuser)
    );

    a_sat_max: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == smag_pkg::WordMax)
        else $error("saturated word not at maximum");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled output word changed");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    a_len_known: assert property (@(posedge clk) disable iff (!rst_n)
        len_vld |-> !$isunknown(len))
        else $error("cube root unknown while valid");

endmodule

// ===== tb/sv/smag_checker.sv =====
`timescale 1ns / 1ps
// Checker for the Smagorinsky viscosity pipeline: watches both stream channels,
// computes the expected viscosity per point and compares. Depends on smag_pkg.
module smag_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_axis_tvalid,
    input  logic                         s_axis_tready,
    input  logic [159:0]                 s_axis_tdata,
    input  logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    input  logic [31:0]                  m_axis_tdata,
    input  logic                         m_axis_tuser,
    input  logic                         cfg_we,
    input  logic [smag_pkg::CfgIdxW-1:0] cfg_index,
    input  logic [31:0]                  cfg_data,
    output int                           fail_count,
    output int                           pending
);

    typedef struct packed {
        logic        sat;
        logic [31:0] visc;
    } visc_word_t;

    logic [31:0] mol_visc;
    logic [31:0] density;
    visc_word_t  visc_q[$];

    function automatic logic [32:0] strain_root(input logic [65:0] s);
        logic [32:0] r;
        logic [32:0] c;
        r = '0;
        for (int b = 32; b >= 0; b--)
        begin
            c = r | (33'd1 << b);
            if ({66'd0, c} * {66'd0, c} <= {66'd0, s})
                r = c;
        end
        return r;
    endfunction

    function automatic logic [21:0] vol_length(input logic [63:0] x);
        logic [21:0] r;
        logic [21:0] c;
        r = '0;
        for (int b = 21; b >= 0; b--)
        begin
            c = r | (22'd1 << b);
            if ({44'd0, c} * {44'd0, c} * {44'd0, c} <= {2'd0, x})
                r = c;
        end
        return r;
    endfunction

    function automatic visc_word_t viscosity(input logic [159:0] d);
        logic signed [32:0] ux, uy, vx, vy, sh;
        logic [32:0]        mx, my, ms;
        logic [65:0]        s;
        logic [32:0]        op;
        logic [21:0]        len;
        logic [127:0]       prod;
        logic [32:0]        total;
        visc_word_t         w;
        ux = 33'(signed'(d[31:0]));
        uy = 33'(signed'(d[63:32]));
        vx = 33'(signed'(d[95:64]));
        vy = 33'(signed'(d[127:96]));
        sh = uy + vx;
        mx = ux < 0 ? -ux : ux;
        my = vy < 0 ? -vy : vy;
        ms = sh < 0 ? -sh : sh;
        s = 66'(2 * {33'd0, mx} * {33'd0, mx}) + 66'(2 * {33'd0, my} * {33'd0, my})
            + 66'({33'd0, ms} * {33'd0, ms});
        op = strain_root(s);
        len = vol_length({32'd0, d[159:128]} * {32'd0, d[159:128]});
        prod = {96'd0, density} * {106'd0, len} * {95'd0, op};
        if (prod[127:64] != 0)
            total = 33'h1_0000_0000;
        else
            total = {1'b0, prod[63:32]} + {1'b0, mol_visc};
        w.sat  = total[32];
        w.visc = total[32] ? smag_pkg::WordMax : total[31:0];
        return w;
    endfunction

    assign pending = visc_q.size();

    always_ff @(posedge clk or negedge rst_n)
    begin
        visc_word_t e;
        if (!rst_n)
        begin
            mol_visc   <= '0;
            density    <= smag_pkg::DensityReset;
            fail_count <= 0;
            visc_q.delete();
        end
        else
        begin
            if (cfg_we && cfg_index == smag_pkg::CfgMolVisc)
                mol_visc <= cfg_data;
            else if (cfg_we && cfg_index == smag_pkg::CfgDensity)
                density <= cfg_data;
            if (s_axis_tvalid && s_axis_tready)
                visc_q.push_back(viscosity(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (visc_q.size() == 0)
                begin
                    $display("%0t: unexpected word visc=%h sat=%b", $time,
                             m_axis_tdata, m_axis_tuser);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    e = visc_q.pop_front();
                    if (e.visc !== m_axis_tdata || e.sat !== m_axis_tuser)
                    begin
                        $display("%0t: mismatch expected visc=%h sat=%b actual visc=%h sat=%b",
                                 $time, e.visc, e.sat, m_axis_tdata, m_axis_tuser);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// Stimulus and verdict for the Smagorinsky viscosity pipeline.
// Depends on smag_pkg, smagorinsky_eddy_viscosity_2d_top and smag_checker.
module testbench;

    localparam int Latency = 39;
    localparam int Limit   = 20000;
    localparam logic [smag_pkg::CfgIdxW-1:0] CfgUnused = 2'd3;

    logic                         clk = 0;
    logic                         rst_n = 0;
    logic                         s_axis_tvalid = 0;
    logic                         s_axis_tready;
    logic [159:0]                 s_axis_tdata = '0;
    logic                         m_axis_tvalid;
    logic                         m_axis_tready = 0;
    logic [31:0]                  m_axis_tdata;
    logic                         m_axis_tuser;
    logic                         cfg_we = 0;
    logic [smag_pkg::CfgIdxW-1:0] cfg_index = '0;
    logic [31:0]                  cfg_data = '0;
    int                           fail_count;
    int                           pending;
    int                           send_idle = 0;
    int                           recv_idle = 0;
    bit                           hold_off = 0;
    int                           quiet = 0;

    always #5 clk = ~clk;

    smagorinsky_eddy_viscosity_2d_top dut (.*);
    smag_checker chk (.*);

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet > Limit)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge clk)
        m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_idle);

    task automatic write_reg(input logic [smag_pkg::CfgIdxW-1:0] idx, input logic [31:0] v);
        cfg_we    <= 1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        cfg_we    <= 0;
    endtask

    task automatic drain();
        while (pending != 0)
            @(posedge clk);
        repeat (Latency + 5) @(posedge clk);
    endtask

    task automatic send_point(input logic [159:0] d);
        while ($urandom_range(99) < send_idle)
        begin
            s_axis_tvalid <= 0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata  <= d;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    function automatic logic [31:0] grad();
        case ($urandom_range(5))
            0: return $urandom;
            1: return 32'($signed($urandom_range(131072)) - 65536);
            2: return 32'($signed($urandom_range(2000000)) - 1000000);
            3: return {{16{1'b0}}, 16'($urandom)} ^ {32{$urandom_range(1) == 1}};
            default: return 32'($signed($urandom_range(40000)) - 20000) <<< $urandom_range(12);
        endcase
    endfunction

    function automatic logic [31:0] volume();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $urandom_range(1 << 24);
            default: return $urandom_range(4096) << $urandom_range(20);
        endcase
    endfunction

    task automatic random_points(input int n);
        for (int i = 0; i < n; i++)
            send_point({volume(), grad(), grad(), grad(), grad()});
        s_axis_tvalid <= 0;
    endtask

    initial
    begin
        logic [31:0] edge_g [6];
        logic [31:0] edge_v [4];
        edge_g = '{32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0001_0000,
                   32'hFFFF_0000};
        edge_v = '{32'h0, 32'hFFFF_FFFF, 32'h0100_0000, 32'h1};
        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed corners at reset settings
        for (int i = 0; i < 6; i++)
            send_point({edge_v[i % 4], edge_g[i], edge_g[5 - i], edge_g[(i + 2) % 6],
                        edge_g[(i + 3) % 6]});
        send_point({32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
        send_point({32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h0});
        send_point({32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                    32'h8000_0000});
        send_point({32'h0100_0000, 32'h0, 32'h0001_0000, 32'hFFFF_0000, 32'h0});
        s_axis_tvalid <= 0;
        drain();
        write_reg(smag_pkg::CfgMolVisc, 32'hFFFF_FFFF);
        write_reg(smag_pkg::CfgDensity, 32'hFFFF_FFFF);
        write_reg(CfgUnused, 32'h1234_5678);
        send_point({32'h0, 32'h0, 32'h0, 32'h0, 32'h0});
        send_point({32'h0100_0000, 32'h0, 32'h0, 32'h0, 32'h0001_0000});
        s_axis_tvalid <= 0;
        drain();
        write_reg(smag_pkg::CfgMolVisc, 32'h0);
        send_point({32'h0100_0000, 32'h0, 32'h0, 32'h0, 32'h0001_0000});
        s_axis_tvalid <= 0;
        drain();
        write_reg(smag_pkg::CfgDensity, 32'h0);
        write_reg(smag_pkg::CfgMolVisc, 32'h0003_0000);
        send_point({32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h1, 32'h1, 32'h7FFF_FFFF});
        s_axis_tvalid <= 0;
        drain();

        // long receiver hold-off while points keep coming
        hold_off <= 1;
        fork
            begin
                repeat (200) @(posedge clk);
                hold_off <= 0;
            end
            random_points(100);
        join
        drain();

        send_idle = 14;
        recv_idle = 88;
        write_reg(smag_pkg::CfgMolVisc, $urandom);
        write_reg(smag_pkg::CfgDensity, $urandom_range(1 << 20));
        random_points(550);
        drain();

        send_idle = 88;
        recv_idle = 14;
        write_reg(smag_pkg::CfgMolVisc, $urandom_range(1 << 16));
        write_reg(smag_pkg::CfgDensity, 32'h0001_0000);
        random_points(550);
        drain();

        send_idle = 0;
        recv_idle = 0;
        write_reg(smag_pkg::CfgMolVisc, $urandom);
        write_reg(smag_pkg::CfgDensity, $urandom);
        random_points(630);
        drain();

        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
